### design/qdt_pkg.sv
// shared constants, types and register codes of the quadratic distance transform
package qdt_pkg;

    localparam int MAX_LEN  = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int ZA_W     = 7;
    localparam int SAMPLE_W = 32;
    localparam int VAL_W    = 48;
    localparam int DEN_W    = 38;
    localparam int DVD_W    = 64;
    localparam int POS_W    = 14;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] MAX_OUT = 7'd64;
    localparam logic [VAL_W-1:0] B_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] B_MIN   = 48'h8000_0000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd4;

    typedef struct packed {
        logic [30:0] quad;
        logic [31:0] lin;
        logic [10:0] start;
        logic [6:0]  count;
        logic [4:0]  stride;
    } cfg_t;

    // one queued word, tagged by the front end
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                keep;
        logic                first;
        logic [IDX_W-1:0]    idx;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] quot;
    } div_rsp_t;

endpackage

### design/qdt_front.sv
// input side: accepts words, tags store index and run position, two-entry queue
module qdt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [qdt_pkg::SAMPLE_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    output qdt_pkg::item_t                 q_item,
    output logic                           q_valid,
    input  logic                           q_ready
);
    import qdt_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [1:0]       fill_reg;
    logic             wptr_reg;
    logic             rptr_reg;
    item_t            fifo_reg [2];
    item_t            tag;
    logic             push;
    logic             pop;

    // classify the incoming word
    always_comb
    begin
        tag.sample = s_tdata;
        tag.last   = s_tlast;
        tag.keep   = (count_reg < CNT_W'(MAX_LEN));
        tag.first  = (count_reg == '0);
        tag.idx    = count_reg[IDX_W-1:0];
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = fifo_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // run counter and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fill_reg  <= '0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                if (s_tlast)
                    count_reg <= '0;
                else if (tag.keep)
                    count_reg <= count_reg + 1'b1;
                wptr_reg <= !wptr_reg;
            end
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wptr_reg] <= tag;
    end

endmodule

### design/qdt_div.sv
// iterative divider for boundary points: floor(num * 2^16 / den), saturated to 48 bits
module qdt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  qdt_pkg::div_req_t  req,
    output qdt_pkg::div_rsp_t  rsp
);
    import qdt_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;

    logic [VAL_W-1:0] num_abs;
    logic [DEN_W+1:0] trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic             sat;
    logic [VAL_W-1:0] mag;

    assign num_abs  = req.num[VAL_W-1] ? (~req.num + 1'b1) : req.num;
    assign trial    = {1'b0, rem_reg, dvd_reg[DVD_W-1]} - {2'b00, den_reg};
    assign ge       = !trial[DEN_W+1];
    assign rem_next = ge ? trial[DEN_W-1:0] : {rem_reg[DEN_W-2:0], dvd_reg[DVD_W-1]};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, quotient shifts into the dividend register
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            dvd_reg <= {1'b0, num_abs[VAL_W-2:0], 16'd0};
            den_reg <= req.den;
            neg_reg <= req.num[VAL_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    // round toward minus infinity and saturate
    assign sat = |dvd_reg[DVD_W-1:VAL_W-1];
    assign mag = {1'b0, dvd_reg[VAL_W-2:0]} + VAL_W'(neg_reg && (rem_reg != '0));

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (sat)
            rsp.quot = neg_reg ? B_MIN : B_MAX;
        else
            rsp.quot = neg_reg ? (~mag + 1'b1) : mag;
    end

endmodule

### design/qdt_back.sv
// back end: envelope update with stored vertices and boundaries, then result walk
module qdt_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qdt_pkg::cfg_t                cfg,
    input  qdt_pkg::item_t               q_item,
    input  logic                         q_valid,
    output logic                         q_ready,
    output qdt_pkg::div_req_t            div_req,
    input  qdt_pkg::div_rsp_t            div_rsp,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [qdt_pkg::VAL_W-1:0]    m_value,
    output logic [qdt_pkg::IDX_W-1:0]    m_index,
    output logic                         m_last
);
    import qdt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDV   = 4'd1;
    localparam logic [3:0] S_RDF   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_PROD  = 4'd4;
    localparam logic [3:0] S_DIVGO = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_EMIT0 = 4'd7;
    localparam logic [3:0] S_WRD   = 4'd8;
    localparam logic [3:0] S_WCMP  = 4'd9;
    localparam logic [3:0] S_ERDV  = 4'd10;
    localparam logic [3:0] S_ERDF  = 4'd11;
    localparam logic [3:0] S_EMUL  = 4'd12;
    localparam logic [3:0] S_EPROD = 4'd13;
    localparam logic [3:0] S_ESUM  = 4'd14;

    // stores
    logic [SAMPLE_W-1:0] smem [MAX_LEN];
    logic [IDX_W-1:0]    vmem [MAX_LEN];
    logic [VAL_W-1:0]    zmem [MAX_LEN+1];

    // control state
    logic [3:0]        state_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  top_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              out_valid_reg;

    // datapath registers
    item_t               cur_reg;
    logic [IDX_W-1:0]    vrd_reg;
    logic [SAMPLE_W-1:0] frd_reg;
    logic [VAL_W-1:0]    zrd_reg;
    logic [11:0]         sq_reg;
    logic [IDX_W-1:0]    d_reg;
    logic [32:0]         fdiff_reg;
    logic [42:0]         pa_reg;
    logic [38:0]         pb_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [23:0]         dd_reg;
    logic [45:0]         ebd_reg;
    logic [54:0]         ad2_reg;
    logic [VAL_W-1:0]    out_val_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_last_reg;

    logic [30:0]         a_eff;
    logic                pop;
    logic                pop_more;
    logic                acc_vtx;
    logic [IDX_W-1:0]    k_inc;
    logic                v_we;
    logic [IDX_W-1:0]    v_waddr;
    logic [IDX_W-1:0]    v_wdata;
    logic [ZA_W-1:0]     z_raddr;
    logic [ZA_W-1:0]     z_waddr;
    logic                slot_free;
    logic [VAL_W-1:0]    pos_q16;
    logic                walk_adv;
    logic [11:0]         sq_c;
    logic [32:0]         fdiff_c;
    logic [42:0]         pa_c;
    logic signed [38:0]  pb_c;
    logic [36:0]         ad_c;
    logic [VAL_W-1:0]    num_c;
    logic signed [POS_W-1:0] ed;
    logic signed [27:0]  ed_sq;
    logic signed [45:0]  eb_c;
    logic [54:0]         ad2_c;
    logic [57:0]         val_c;
    logic [VAL_W-1:0]    val_sat;
    logic [CNT_W-1:0]    n_cut;
    logic                last_i;

    // zero coefficient is taken as the smallest positive step
    assign a_eff = (cfg.quad == '0) ? 31'd1 : cfg.quad;

    // handshake and store control
    assign q_ready   = (state_reg == S_IDLE);
    assign pop       = q_ready && q_valid;
    assign k_inc     = k_reg + 1'b1;
    assign pop_more  = (k_reg != '0) && ($signed(div_rsp.quot) <= $signed(zrd_reg));
    assign acc_vtx   = (state_reg == S_DIVW) && div_rsp.done && !pop_more;
    assign v_we      = (pop && q_item.keep && q_item.first) || acc_vtx;
    assign v_waddr   = acc_vtx ? k_inc : '0;
    assign v_wdata   = acc_vtx ? cur_reg.idx : '0;
    assign z_waddr   = {1'b0, k_inc};
    assign z_raddr   = (state_reg == S_WRD) ? ({1'b0, k_reg} + 1'b1) : {1'b0, k_reg};
    assign slot_free = !out_valid_reg || m_tready;

    // query walk compare
    assign pos_q16  = {{(VAL_W-POS_W-16){pos_reg[POS_W-1]}}, pos_reg, 16'd0};
    assign walk_adv = (k_reg < top_reg) && ($signed(zrd_reg) < $signed(pos_q16));

    // boundary numerator and denominator terms
    assign sq_c    = 12'(cur_reg.idx * cur_reg.idx) - 12'(vrd_reg * vrd_reg);
    assign fdiff_c = {cur_reg.sample[SAMPLE_W-1], cur_reg.sample}
                   - {frd_reg[SAMPLE_W-1], frd_reg};
    assign pa_c    = 43'(a_eff) * 43'(sq_reg);
    assign pb_c    = $signed(cfg.lin) * $signed({1'b0, d_reg});
    assign ad_c    = 37'(a_eff) * 37'(d_reg);
    assign num_c   = {{15{fdiff_reg[32]}}, fdiff_reg} - {{9{pb_reg[38]}}, pb_reg}
                   + {5'd0, pa_reg};

    always_comb
    begin
        div_req.start = (state_reg == S_DIVGO);
        div_req.num   = num_c;
        div_req.den   = den_reg;
    end

    // result value terms
    assign ed     = $signed(pos_reg) - $signed({{(POS_W-IDX_W){1'b0}}, vrd_reg});
    assign ed_sq  = ed * ed;
    assign eb_c   = $signed(cfg.lin) * ed;
    assign ad2_c  = 55'(a_eff) * 55'(dd_reg);
    assign val_c  = {3'd0, ad2_reg} + {{12{ebd_reg[45]}}, ebd_reg}
                  + {{26{frd_reg[SAMPLE_W-1]}}, frd_reg};
    assign val_sat = ((val_c[57:47] == '0) || (val_c[57:47] == '1)) ? val_c[VAL_W-1:0]
                   : (val_c[57] ? B_MIN : B_MAX);
    assign n_cut  = (cfg.count > MAX_OUT) ? MAX_OUT : cfg.count;
    assign last_i = (i_reg == (n_reg - 1'b1));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            top_reg       <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_ESUM && slot_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.keep && q_item.first)
                            top_reg <= '0;
                        if (q_item.keep && !q_item.first)
                        begin
                            k_reg     <= top_reg;
                            state_reg <= S_RDV;
                        end
                        else if (q_item.last)
                            state_reg <= S_EMIT0;
                    end
                end
                S_RDV:   state_reg <= S_RDF;
                S_RDF:   state_reg <= S_SQ;
                S_SQ:    state_reg <= S_PROD;
                S_PROD:  state_reg <= S_DIVGO;
                S_DIVGO: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        if (pop_more)
                        begin
                            k_reg     <= k_reg - 1'b1;
                            state_reg <= S_RDV;
                        end
                        else
                        begin
                            top_reg   <= k_inc;
                            state_reg <= cur_reg.last ? S_EMIT0 : S_IDLE;
                        end
                    end
                end
                S_EMIT0:
                begin
                    if (cfg.count == '0)
                    begin
                        top_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        n_reg     <= n_cut;
                        i_reg     <= '0;
                        k_reg     <= '0;
                        pos_reg   <= {{(POS_W-11){cfg.start[10]}}, cfg.start};
                        state_reg <= S_WRD;
                    end
                end
                S_WRD:   state_reg <= S_WCMP;
                S_WCMP:
                begin
                    if (walk_adv)
                    begin
                        k_reg     <= k_inc;
                        state_reg <= S_WRD;
                    end
                    else
                        state_reg <= S_ERDV;
                end
                S_ERDV:  state_reg <= S_ERDF;
                S_ERDF:  state_reg <= S_EMUL;
                S_EMUL:  state_reg <= S_EPROD;
                S_EPROD: state_reg <= S_ESUM;
                S_ESUM:
                begin
                    if (slot_free)
                    begin
                        i_reg   <= i_reg + 1'b1;
                        pos_reg <= pos_reg + {{(POS_W-5){1'b0}}, cfg.stride};
                        if (last_i)
                        begin
                            top_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_WRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // stores with registered reads
    always_ff @(posedge clk)
    begin
        if (pop && q_item.keep)
            smem[q_item.idx] <= q_item.sample;
        if (v_we)
            vmem[v_waddr] <= v_wdata;
        if (acc_vtx)
            zmem[z_waddr] <= div_rsp.quot;
        vrd_reg <= vmem[k_reg];
        zrd_reg <= zmem[z_raddr];
        frd_reg <= smem[vrd_reg];
    end

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_item;
        if (state_reg == S_SQ)
        begin
            sq_reg    <= sq_c;
            d_reg     <= cur_reg.idx - vrd_reg;
            fdiff_reg <= fdiff_c;
        end
        if (state_reg == S_PROD)
        begin
            pa_reg  <= pa_c;
            pb_reg  <= pb_c;
            den_reg <= {ad_c, 1'b0};
        end
        if (state_reg == S_EMUL)
        begin
            dd_reg  <= ed_sq[23:0];
            ebd_reg <= eb_c;
        end
        if (state_reg == S_EPROD)
            ad2_reg <= ad2_c;
        if (state_reg == S_ESUM && slot_free)
        begin
            out_val_reg  <= val_sat;
            out_idx_reg  <= vrd_reg;
            out_last_reg <= last_i;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_val_reg;
    assign m_index  = out_idx_reg;
    assign m_last   = out_last_reg;

endmodule

### design/quadratic_distance_transform_1d.sv
// Top level of the 1-D quadratic distance transform, two-word queue before the envelope engine.
// Per stored sample: the word is taken, then one boundary evaluation plus one per popped vertex,
// each waiting on the one-bit-per-cycle divider. First and dropped samples need no evaluation;
// a last word passes S_EMIT0 before the query walk. Per result: S_WRD and S_WCMP once per
// boundary passed and once more, then S_ERDV to S_ESUM, which waits while the output stalls.
// Reset clears control and configuration to defaults; stores are written before use.
module quadratic_distance_transform_1d (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [31:0] sample
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [55:0]                     m_axis_tdata,  // [47:0] min_value, [53:48] arg_index
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [qdt_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [qdt_pkg::CFG_W-1:0]       cfg_wdata
);
    import qdt_pkg::*;

    cfg_t             cfg_reg;
    item_t            q_item;
    logic             q_valid;
    logic             q_ready;
    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic [VAL_W-1:0] m_value;
    logic [IDX_W-1:0] m_index;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quad   <= 31'd65536;
            cfg_reg.lin    <= '0;
            cfg_reg.start  <= '0;
            cfg_reg.count  <= 7'd64;
            cfg_reg.stride <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_QUAD:   cfg_reg.quad   <= cfg_wdata[30:0];
                REG_LIN:    cfg_reg.lin    <= cfg_wdata;
                REG_START:  cfg_reg.start  <= cfg_wdata[10:0];
                REG_COUNT:  cfg_reg.count  <= cfg_wdata[6:0];
                REG_STRIDE: cfg_reg.stride <= cfg_wdata[4:0];
                default:    ;
            endcase
        end
    end

    qdt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    qdt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    qdt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_value  (m_value),
        .m_index  (m_index),
        .m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, m_index, m_value};

    // divider is only started when idle
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a start always makes the divider busy
    a_div_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> div_rsp.busy)
        else $error("divider did not start");

    // a queued word is only taken while no division is in flight
    a_pop_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |-> !div_rsp.busy)
        else $error("word taken during a division");

endmodule
